/* rtl/distance_coefficient_filter_defines.svh */
// Assertion macros shared by the distance coefficient filter RTL.
`ifndef DISTANCE_COEFFICIENT_FILTER_DEFINES_SVH
`define DISTANCE_COEFFICIENT_FILTER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define DCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define DCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error(msg);
`else
`define DCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/dcf_pkg.sv */
// Shared types and constants of the distance coefficient filter.
package dcf_pkg;

	// Width of the length register write data.
	localparam int CFG_BITS = 6;
	// Width of one weight chunk fed to the shared multiplier.
	localparam int CHUNK_BITS = 32;
	// Length after reset.
	localparam int LEN_RESET = 10;

	// Per-cycle commands broadcast to every cell of the chain.
	typedef struct packed {
		logic shift;       // window moves one place toward older
		logic load_older;  // stream register takes the older neighbor's sample
		logic load_own;    // stream register takes the cell's own sample
		logic step;        // stream register takes the older neighbor's stream value
		logic sq_en;       // square the difference of own sample and stream value
		logic clr_w;       // clear the weight accumulator
		logic acc;         // add the registered square into the weight
		logic drain;       // weight moves one place toward cell 0
	} cell_ctl_t;

endpackage

/* rtl/dcf_ifc.sv */
// Handshake channel interfaces of the distance coefficient filter.
interface dcf_sample_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface dcf_result_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

interface dcf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dcf_pkg::CFG_BITS-1:0]  window_length;
	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

/* rtl/dcf_cell.sv */
// One cell of the chain: a window sample, a stream value and a weight accumulator.
module dcf_cell #(
	parameter int SAMPLE_BITS = 24,
	parameter int W_BITS      = 54
) (
	input  logic                          clk,
	input  dcf_pkg::cell_ctl_t            ctl,
	input  logic signed [SAMPLE_BITS-1:0] newer_win,
	input  logic signed [SAMPLE_BITS-1:0] older_win,
	input  logic signed [SAMPLE_BITS-1:0] older_str,
	input  logic [W_BITS-1:0]             older_w,
	output logic signed [SAMPLE_BITS-1:0] win,
	output logic signed [SAMPLE_BITS-1:0] str,
	output logic [W_BITS-1:0]             w
);
	localparam int SQ_BITS = 2 * SAMPLE_BITS + 1;

	logic signed [SAMPLE_BITS-1:0] win_q;
	logic signed [SAMPLE_BITS-1:0] str_q;
	logic [SQ_BITS-1:0]            sq_q;
	logic [W_BITS-1:0]             w_q;
	logic signed [SAMPLE_BITS:0]   diff;
	logic [SAMPLE_BITS:0]          mag;
	logic [2*SAMPLE_BITS+1:0]      sq_full;

	always_comb begin
		diff    = {win_q[SAMPLE_BITS-1], win_q} - {str_q[SAMPLE_BITS-1], str_q};
		// The magnitude of the most negative difference still fits unsigned.
		mag     = diff[SAMPLE_BITS] ? -diff : diff;
		sq_full = mag * mag;
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= newer_win;
		end
		if (ctl.load_older) begin
			str_q <= older_win;
		end else if (ctl.load_own) begin
			str_q <= win_q;
		end else if (ctl.step) begin
			str_q <= older_str;
		end
		if (ctl.sq_en) begin
			sq_q <= sq_full[SQ_BITS-1:0];
		end
		if (ctl.clr_w) begin
			w_q <= '0;
		end else if (ctl.acc) begin
			w_q <= w_q + W_BITS'(sq_q);
		end else if (ctl.drain) begin
			w_q <= older_w;
		end
	end

	assign win = win_q;
	assign str = str_q;
	assign w   = w_q;
endmodule

/* rtl/dcf_div.sv */
// Restoring divider: signed numerator by unsigned denominator, one quotient bit a cycle.
module dcf_div #(
	parameter int SAMPLE_BITS = 24,
	parameter int NUM_BITS    = 85,
	parameter int DEN_BITS    = 59
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [NUM_BITS-1:0]    num,
	input  logic [DEN_BITS-1:0]           den,
	output logic                          done,
	output logic [SAMPLE_BITS-1:0]        quotient
);
	localparam int CW = $clog2(SAMPLE_BITS + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   zero_q;
	logic [NUM_BITS-1:0]    r_q;
	logic [NUM_BITS-1:0]    d_q;
	logic [SAMPLE_BITS-1:0] q_q;
	logic                   fits;

	assign fits = r_q >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SAMPLE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[NUM_BITS-1];
			r_q    <= num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
			d_q    <= NUM_BITS'(den) << (SAMPLE_BITS - 1);
			zero_q <= (den == '0);
			q_q    <= '0;
		end else if (busy_q) begin
			if (fits) begin
				r_q <= r_q - d_q;
			end
			q_q <= {q_q[SAMPLE_BITS-2:0], fits};
			d_q <= d_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : (neg_q ? -q_q : q_q);
endmodule

/* rtl/distance_coefficient_filter.sv */
// Top level of the distance coefficient filter: cell chain, weight MAC, divider, control.
//
//   channel        dir   payload              transaction
//   price_stream   in    sample  [S-1:0]      one sample into the window
//   filter_stream  out   filtered[S-1:0]      one weighted average
//   length_cfg     in    window_length[5:0]   new length, restarts warm-up
//
// A sample that completes warm-up blocks the input while its pass runs: load, the distance
// steps, flush, the drain steps over each weight's 32-bit chunks, the setup states FIN and
// DSTART, the divider and the output load.
// Warm-up samples start no pass, so input stays ready; a pending length write goes first.
// Reset clears control state only; the window needs no clearing.
// A result waiting in the output register stalls only the output load of the next pass.
`include "distance_coefficient_filter_defines.svh"

module distance_coefficient_filter #(
	parameter int MAX_LENGTH  = 32,
	parameter int SAMPLE_BITS = 24
) (
	input logic          clk,
	input logic          arst_n,
	dcf_sample_if.sink   price_stream,
	dcf_result_if.source filter_stream,
	dcf_cfg_if.sink      length_cfg
);
	localparam int DEPTH   = 2 * MAX_LENGTH;
	localparam int LB      = $clog2(MAX_LENGTH);
	localparam int W_BITS  = 2 * SAMPLE_BITS + 1 + LB;
	localparam int DEN_BITS = W_BITS + LB;
	localparam int NUM_BITS = W_BITS + SAMPLE_BITS + LB + 1;
	localparam int CB      = dcf_pkg::CHUNK_BITS;
	localparam int PP      = (W_BITS + CB - 1) / CB;
	localparam int KW      = (PP > 1) ? $clog2(PP) : 1;
	localparam int LW      = $clog2(MAX_LENGTH + 1);
	localparam int WCW     = $clog2(DEPTH);
	localparam int LEN_INIT = (dcf_pkg::LEN_RESET > MAX_LENGTH) ? MAX_LENGTH
		: dcf_pkg::LEN_RESET;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOAD   = 4'd1;
	localparam logic [3:0] ST_STEP   = 4'd2;
	localparam logic [3:0] ST_FLUSH  = 4'd3;
	localparam logic [3:0] ST_DRAIN  = 4'd4;
	localparam logic [3:0] ST_FIN    = 4'd5;
	localparam logic [3:0] ST_DSTART = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]     state_q;
	logic [LW-1:0]  len_q;
	logic [WCW-1:0] warm_q;
	logic [LW-1:0]  cnt_q;
	logic [KW-1:0]  k_q;
	logic           sq_v_q;

	logic signed [SAMPLE_BITS-1:0] win_a [DEPTH];
	logic signed [SAMPLE_BITS-1:0] str_a [DEPTH];
	logic [W_BITS-1:0]             w_a   [DEPTH];
	dcf_pkg::cell_ctl_t            ctl;

	logic                          in_acc;
	logic                          cfg_wr;
	logic [LW:0]                   thr;
	logic                          warm_done;
	logic [LW-1:0]                 len_new;

	logic [CB*PP-1:0]              w_ext;
	logic [CB-1:0]                 chunk;
	logic [SAMPLE_BITS-1:0]        pm0;
	logic [CB+SAMPLE_BITS-1:0]     prod_s1;
	logic [KW-1:0]                 k_s1;
	logic                          neg_s1;
	logic                          pv_s1;
	logic [NUM_BITS-1:0]           shifted;
	logic signed [NUM_BITS-1:0]    num_q;
	logic [DEN_BITS-1:0]           den_q;

	logic                          div_done;
	logic [SAMPLE_BITS-1:0]        quotient;
	logic [SAMPLE_BITS-1:0]        res_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        filtered_q;
	logic                          out_load;

	assign in_acc    = price_stream.valid && price_stream.ready;
	assign cfg_wr    = length_cfg.valid && length_cfg.ready;
	assign thr       = {len_q, 1'b0} - 1'b1;
	assign warm_done = ({1'b0, warm_q} >= thr);
	assign price_stream.ready = (state_q == ST_IDLE) && !length_cfg.valid;
	assign length_cfg.ready   = (state_q == ST_IDLE);

	always_comb begin
		if (length_cfg.window_length == '0) begin
			len_new = LW'(1);
		end else if (int'(length_cfg.window_length) > MAX_LENGTH) begin
			len_new = LW'(MAX_LENGTH);
		end else begin
			len_new = LW'(length_cfg.window_length);
		end
	end

	always_comb begin
		ctl            = '0;
		ctl.shift      = in_acc;
		ctl.load_older = (state_q == ST_LOAD);
		ctl.clr_w      = (state_q == ST_LOAD);
		ctl.sq_en      = (state_q == ST_STEP);
		ctl.acc        = sq_v_q && ((state_q == ST_STEP) || (state_q == ST_FLUSH));
		ctl.load_own   = (state_q == ST_FLUSH);
		ctl.step       = (state_q == ST_STEP)
			|| ((state_q == ST_DRAIN) && (k_q == KW'(PP - 1)));
		ctl.drain      = (state_q == ST_DRAIN) && (k_q == KW'(PP - 1));
	end

	for (genvar c = 0; c < DEPTH; c++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] newer_win;
		logic signed [SAMPLE_BITS-1:0] older_win;
		logic signed [SAMPLE_BITS-1:0] older_str;
		logic [W_BITS-1:0]             older_w;
		if (c == 0) begin : g_first
			assign newer_win = price_stream.sample;
		end else begin : g_mid
			assign newer_win = win_a[c-1];
		end
		if (c == DEPTH - 1) begin : g_last
			assign older_win = '0;
			assign older_str = '0;
			assign older_w   = '0;
		end else begin : g_inner
			assign older_win = win_a[c+1];
			assign older_str = str_a[c+1];
			assign older_w   = w_a[c+1];
		end
		dcf_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.W_BITS     (W_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.newer_win(newer_win),
			.older_win(older_win),
			.older_str(older_str),
			.older_w  (older_w),
			.win      (win_a[c]),
			.str      (str_a[c]),
			.w        (w_a[c])
		);
	end

	// Cell 0 presents one weight and its sample through the drain steps over its chunks.
	assign w_ext   = (CB*PP)'(w_a[0]);
	assign chunk   = w_ext[CB*k_q +: CB];
	assign pm0     = str_a[0][SAMPLE_BITS-1] ? -str_a[0] : str_a[0];
	assign shifted = NUM_BITS'(prod_s1) << (CB * k_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= LW'(LEN_INIT);
			warm_q      <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			sq_v_q      <= 1'b0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sq_v_q <= (state_q == ST_STEP);
			pv_s1  <= (state_q == ST_DRAIN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (filter_stream.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_wr) begin
						len_q  <= len_new;
						warm_q <= '0;
					end else if (in_acc) begin
						if (warm_done) begin
							state_q <= ST_LOAD;
						end else begin
							warm_q <= warm_q + 1'b1;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= (len_q == LW'(1)) ? ST_FLUSH : ST_STEP;
				end
				ST_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == len_q - LW'(2)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					cnt_q   <= '0;
					k_q     <= '0;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (k_q == KW'(PP - 1)) begin
						k_q   <= '0;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == len_q - LW'(1)) begin
							state_q <= ST_FIN;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || filter_stream.ready);

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			prod_s1 <= chunk * pm0;
			k_s1    <= k_q;
			neg_s1  <= str_a[0][SAMPLE_BITS-1];
		end
		if (state_q == ST_FLUSH) begin
			num_q <= '0;
			den_q <= '0;
		end else begin
			if ((state_q == ST_DRAIN) && (k_q == '0)) begin
				den_q <= den_q + DEN_BITS'(w_a[0]);
			end
			if (pv_s1) begin
				num_q <= neg_s1 ? num_q - signed'(shifted) : num_q + signed'(shifted);
			end
		end
		if (div_done) begin
			res_q <= quotient;
		end
		if (out_load) begin
			filtered_q <= res_q;
		end
	end

	dcf_div #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.NUM_BITS   (NUM_BITS),
		.DEN_BITS   (DEN_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_DSTART),
		.num     (num_q),
		.den     (den_q),
		.done    (div_done),
		.quotient(quotient)
	);

	assign filter_stream.valid    = out_valid_q;
	assign filter_stream.filtered = filtered_q;

	// A sample taken during warm-up must not start a pass.
	`DCF_ASSERT_NXT(a_warmup_no_pass, clk, arst_n, in_acc && !cfg_wr && !warm_done, state_q == ST_IDLE, "pass started during warm-up")
	// The drain index stays inside the current length.
	`DCF_ASSERT_IMP(a_drain_in_range, clk, arst_n, state_q == ST_DRAIN, cnt_q < len_q, "drain index beyond length")
	// All weights zero leaves the weighted sum zero.
	`DCF_ASSERT_IMP(a_zero_den_num, clk, arst_n, (state_q == ST_DSTART) && (den_q == '0), num_q == '0, "zero weight sum with nonzero numerator")
endmodule

/* verif/tb.sv */
// Self-checking testbench of the distance coefficient filter.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SBITS = 24;
	localparam int MAXLEN = 32;
	localparam int DEPTH = 2 * MAXLEN;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int NUM_RANDOM = 800;
	localparam int NUM_DIRECTED = 20;

	logic clk;
	logic arst_n;

	dcf_sample_if #(.SAMPLE_BITS(SBITS)) price_stream();
	dcf_result_if #(.SAMPLE_BITS(SBITS)) filter_stream();
	dcf_cfg_if length_cfg();

	distance_coefficient_filter #(.MAX_LENGTH(MAXLEN), .SAMPLE_BITS(SBITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.price_stream(price_stream.sink),
		.filter_stream(filter_stream.source),
		.length_cfg(length_cfg.sink)
	);

	// Predictor state.
	logic signed [SBITS-1:0] history [DEPTH];
	int unsigned newest;
	int unsigned fill_count;
	int unsigned taps;

	logic signed [SBITS-1:0] expected_averages [$];
	int errors;
	int results_seen;
	int samples_sent;
	longint cycles;

	typedef struct {
		logic signed [SBITS-1:0] sample;
		bit has_result;
		logic signed [SBITS-1:0] result;
	} directed_row_t;

	directed_row_t directed_rows [NUM_DIRECTED];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("tb: mismatch at cycle %0d: %s", cycles, what);
	endtask

	function automatic logic signed [SBITS-1:0] tap_at(input int unsigned k);
		return history[(newest + DEPTH - (k % DEPTH)) % DEPTH];
	endfunction

	function automatic int unsigned clamp_length(input logic [dcf_pkg::CFG_BITS-1:0] value);
		if (value < 1)
			return 1;
		if (value > MAXLEN)
			return MAXLEN;
		return int'(value);
	endfunction

	// Weighted average over the newest taps; returns 1 when a result is due.
	function automatic bit weigh_sample(input logic signed [SBITS-1:0] s,
			output logic signed [SBITS-1:0] average);
		logic signed [127:0] num;
		logic signed [127:0] den;
		logic signed [127:0] weight;
		logic signed [127:0] diff;
		logic signed [127:0] quot;
		newest = (newest + 1) % DEPTH;
		history[newest] = s;
		average = '0;
		if (fill_count < 2 * taps - 1) begin
			fill_count++;
			return 0;
		end
		num = 0;
		den = 0;
		for (int c = 0; c < taps; c++) begin
			weight = 0;
			for (int lb = 1; lb < taps; lb++) begin
				diff = 128'(tap_at(c)) - 128'(tap_at(c + lb));
				weight += diff * diff;
			end
			den += weight;
			num += weight * 128'(tap_at(c));
		end
		if (den != 0) begin
			// Signed division truncates toward zero.
			quot = num / den;
			average = quot[SBITS-1:0];
		end
		return 1;
	endfunction

	task automatic write_length(input logic [dcf_pkg::CFG_BITS-1:0] value);
		length_cfg.valid <= 1'b1;
		length_cfg.window_length <= value;
		do @(posedge clk); while (!length_cfg.ready);
		length_cfg.valid <= 1'b0;
		taps = clamp_length(value);
		fill_count = 0;
	endtask

	// Drops the sample valid before the sender pauses.
	task automatic idle_sender();
		price_stream.valid <= 1'b0;
	endtask

	// Waits for every expected result, then lets a full pass time elapse.
	task automatic drain_results();
		idle_sender();
		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (2 * 128 + 100) @(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SBITS-1:0] s, input bit pre_known,
			input logic signed [SBITS-1:0] known);
		logic signed [SBITS-1:0] avg;
		bit due;
		int idle_cycles;
		idle_cycles = $urandom_range(0, 10);
		if (idle_cycles != 0) begin
			price_stream.valid <= 1'b0;
			repeat (idle_cycles) @(posedge clk);
		end
		price_stream.valid <= 1'b1;
		price_stream.sample <= s;
		do @(posedge clk); while (!price_stream.ready);
		samples_sent++;
		due = weigh_sample(s, avg);
		if (due) begin
			if (pre_known && avg !== known)
				report_mismatch($sformatf("predictor gives %0d, table row %0d", avg, known));
			expected_averages.push_back(pre_known ? known : avg);
		end
	endtask

	function automatic logic signed [SBITS-1:0] random_sample(input int mode,
			input logic signed [SBITS-1:0] base);
		case (mode)
			0: return SBITS'($urandom);
			1: return SBITS'(base + $signed(SBITS'($urandom_range(0, 2048))) - 1024);
			2: return $urandom_range(0, 1) ? {1'b0, {(SBITS-1){1'b1}}} : {1'b1, {(SBITS-1){1'b0}}};
			default: return base;
		endcase
	endfunction

	// Result side: random stalls and field checks.
	initial begin
		int idle_cycles;
		filter_stream.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			idle_cycles = $urandom_range(0, 10);
			if (idle_cycles != 0) begin
				filter_stream.ready <= 1'b0;
				repeat (idle_cycles) @(posedge clk);
			end
			filter_stream.ready <= 1'b1;
			do @(posedge clk); while (!filter_stream.valid);
			results_seen++;
			if (expected_averages.size() == 0)
				report_mismatch($sformatf("unexpected result %0d", filter_stream.filtered));
			else if (filter_stream.filtered !== expected_averages[0])
				report_mismatch($sformatf("filtered %0d, expected %0d",
					filter_stream.filtered, expected_averages.pop_front()));
			else
				void'(expected_averages.pop_front());
		end
	end

	initial begin
		logic signed [SBITS-1:0] level;
		int mode;
		logic [dcf_pkg::CFG_BITS-1:0] lengths [6];
		lengths = '{6'd0, 6'd2, 6'd63, 6'd32, 6'd5, 6'd1};
		cycles = 0;
		errors = 0;
		results_seen = 0;
		samples_sent = 0;
		arst_n = 1'b0;
		price_stream.valid = 1'b0;
		price_stream.sample = '0;
		length_cfg.valid = 1'b0;
		length_cfg.window_length = '0;
		newest = 0;
		fill_count = 0;
		taps = dcf_pkg::LEN_RESET;
		foreach (history[i])
			history[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at length 2: three samples warm up, then each result weighs the
		// two newest samples, each by its squared gap to the next older sample.
		write_length(6'd2);
		directed_rows[0] = '{24'sd100, 0, 0};
		directed_rows[1] = '{24'sd100, 0, 0};
		directed_rows[2] = '{24'sd100, 0, 0};
		directed_rows[3] = '{24'sh7FFFFF, 0, 0};
		directed_rows[4] = '{24'sh800000, 0, 0};
		directed_rows[5] = '{24'sh7FFFFF, 0, 0};
		directed_rows[6] = '{24'sh800000, 0, 0};
		directed_rows[7] = '{-24'sd1, 0, 0};
		directed_rows[8] = '{24'sd1, 0, 0};
		directed_rows[9] = '{24'sd0, 0, 0};
		directed_rows[10] = '{24'sd0, 1, 0};              // only the zero tap carries weight
		directed_rows[11] = '{-24'sd256, 0, 0};
		directed_rows[12] = '{24'sd257, 0, 0};
		directed_rows[13] = '{24'sh555555, 0, 0};
		directed_rows[14] = '{24'shAAAAAA, 0, 0};
		directed_rows[15] = '{24'sh123456, 0, 0};
		directed_rows[16] = '{24'shFEDCBA, 0, 0};
		directed_rows[17] = '{24'sd0, 0, 0};
		directed_rows[18] = '{24'sd0, 0, 0};
		directed_rows[19] = '{24'sd0, 1, 0};              // equal samples give zero weight
		foreach (directed_rows[i])
			send_sample(directed_rows[i].sample, directed_rows[i].has_result,
				directed_rows[i].result);
		drain_results();

		// Random phases over several lengths, extremes included.
		level = '0;
		for (int p = 0; p < 6; p++) begin
			write_length(lengths[p]);
			for (int n = 0; n < NUM_RANDOM / 6; n++) begin
				mode = $urandom_range(0, 9);
				if (mode < 5)
					mode = 1;
				else if (mode < 8)
					mode = 0;
				else if (mode == 8)
					mode = 2;
				else
					mode = 3;
				level = random_sample(mode, level);
				send_sample(level, 0, 0);
				// Hold the sender once per phase until results catch up.
				if (n == 40) begin
					idle_sender();
					while (expected_averages.size() != 0)
						@(posedge clk);
				end
			end
			drain_results();
		end

		$display("tb: %0d samples sent, %0d results checked over lengths 1 to 32",
			samples_sent, results_seen);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/dcf_pkg.sv
rtl/dcf_ifc.sv
rtl/dcf_cell.sv
rtl/dcf_div.sv
rtl/distance_coefficient_filter.sv
verif/tb.sv
